FILE: rtl/register_write_burst_player_assert.svh
// Assertion macros for the register-write burst player.
// Included by the RTL files that carry assertions; relies on clk and arst_n in scope.
`ifndef REGISTER_WRITE_BURST_PLAYER_ASSERT_SVH
`define REGISTER_WRITE_BURST_PLAYER_ASSERT_SVH
`ifndef SYNTHESIS
// plain property
`define RWBP_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("rwbp: assertion failed");
// same-cycle implication
`define RWBP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rwbp: implication failed");
// next-cycle implication
`define RWBP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rwbp: next-cycle implication failed");
`else
`define RWBP_ASSERT(label, prop)
`define RWBP_ASSERT_IMP(label, ante, cons)
`define RWBP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/rwbp_pkg.sv
// Shared types and constants of the register-write burst player.
// No dependencies; imported by rwbp_front, rwbp_back and the top module.
package rwbp_pkg;

	localparam int FIFO_DEPTH = 128;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// silencing pairs queued by a flush: addresses 0 .. SILENCE_LAST, value 0
	localparam logic [7:0] SILENCE_LAST = 8'h17;
	localparam int SILENCE_N  = (FIFO_DEPTH < int'(SILENCE_LAST) + 1) ?
		FIFO_DEPTH : int'(SILENCE_LAST) + 1;
	localparam int SILENCE_WP = SILENCE_N % FIFO_DEPTH;

	localparam logic [7:0] END_SONG_RST  = 8'hFF;
	localparam logic [7:0] END_FRAME_RST = 8'hF1;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_END_SONG  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_FRAME = 1'b1;

	localparam logic [2:0] REQ_PUSH   = 3'd0;
	localparam logic [2:0] REQ_FRAME  = 3'd1;
	localparam logic [2:0] REQ_BUS    = 3'd2;
	localparam logic [2:0] REQ_SONG   = 3'd3;
	localparam logic [2:0] REQ_FLUSH  = 3'd4;
	localparam logic [2:0] REQ_START  = 3'd5;

	// command queue between front and back; depth must be a power of two
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_PUSH,
		CMD_FRAME,
		CMD_BUS,
		CMD_SONG,
		CMD_FLUSH,
		CMD_START
	} cmd_kind_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] write_address;
		logic [7:0] write_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] bus_value;
		logic       data_clock;
		logic       frame_clock;
		logic       bus_phase_done;
		logic       burst_active;
		logic       song_finished;
		logic [7:0] fifo_level;
		logic       push_dropped;
	} out_item_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] addr;
		logic [7:0] value;
	} cmd_t;

endpackage

FILE: rtl/rwbp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rwbp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/rwbp_front.sv
// Front end: takes request transfers, decodes them into commands and queues them.
// Depends on rwbp_pkg.
module rwbp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  rwbp_pkg::in_item_t req,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output rwbp_pkg::cmd_t    cmd
);
	import rwbp_pkg::*;

	cmd_t                cq_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] cq_cnt_q;
	cmd_t                cmd_in;
	logic                push;
	logic                pop;

	always_comb begin
		cmd_in.addr  = req.write_address;
		cmd_in.value = req.write_value;
		unique case (req.req_type)
			REQ_PUSH:  cmd_in.kind = CMD_PUSH;
			REQ_FRAME: cmd_in.kind = CMD_FRAME;
			REQ_BUS:   cmd_in.kind = CMD_BUS;
			REQ_SONG:  cmd_in.kind = CMD_SONG;
			REQ_FLUSH: cmd_in.kind = CMD_FLUSH;
			REQ_START: cmd_in.kind = CMD_START;
			default:   cmd_in.kind = CMD_NOP;
		endcase
	end

	assign req_ready = (cq_cnt_q != CQ_CNT_W'(CQ_DEPTH));
	assign cmd_valid = (cq_cnt_q != '0);
	assign cmd       = cq_q[rd_ptr_q];
	assign push      = req_valid && req_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			cq_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cq_cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cq_cnt_q <= cq_cnt_q + 1'b1;
			end else if (pop && !push) begin
				cq_cnt_q <= cq_cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/rwbp_back.sv
// Back end: pair FIFO, burst engine, frame counter, config registers, result register.
// Depends on rwbp_pkg, rwbp_ram and the assertion macro header.
`include "register_write_burst_player_assert.svh"
module rwbp_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_ready,
	input  rwbp_pkg::cmd_t                     cmd,
	input  logic                               cfg_we,
	input  logic [rwbp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rwbp_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output rwbp_pkg::out_item_t                rsp
);
	import rwbp_pkg::*;

	typedef enum logic [1:0] {
		ST_ISSUE = 2'b01,
		ST_EXEC  = 2'b10
	} st_t;

	st_t                  state_q;
	cmd_t                 cmd_s1;
	logic [PTR_W-1:0]     rp_q, rp_d;
	logic [PTR_W-1:0]     wp_q, wp_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic                 vpp_q, vpp_d;
	logic                 burst_q, burst_d;
	logic                 done_q, done_d;
	logic [1:0]           fc_q, fc_d;
	logic [7:0]           bus_q, bus_d;
	logic                 dclk_q, dclk_d;
	logic [SILENCE_N-1:0] sil_q, sil_d;
	logic [7:0]           end_song_q;
	logic [7:0]           end_frame_q;
	logic                 rsp_valid_q;
	out_item_t            rsp_q;

	logic                 exec_fire;
	logic [15:0]          ram_rdata;
	logic [15:0]          head;
	logic                 sil_hit;
	logic                 mem_we;
	logic                 driven;
	logic                 dropped;
	logic [PTR_W-1:0]     rp_inc;
	logic [PTR_W-1:0]     wp_inc;

	assign cmd_ready = (state_q == ST_ISSUE);
	assign exec_fire = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// read address follows the head pointer; read data is registered and valid in the cycle after issue
	rwbp_ram #(
		.WIDTH(16),
		.DEPTH(FIFO_DEPTH)
	) u_pair_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wp_q),
		.wdata ({cmd_s1.addr, cmd_s1.value}),
		.raddr (rp_q),
		.rdata (ram_rdata)
	);

	assign rp_inc = (rp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
	assign wp_inc = (wp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;

	// slots still holding a silencing pair from the last flush read as {slot, 0}
	always_comb begin
		sil_hit = 1'b0;
		for (int i = 0; i < SILENCE_N; i++) begin
			if (rp_q == PTR_W'(i) && sil_q[i]) begin
				sil_hit = 1'b1;
			end
		end
		head = sil_hit ? {8'(rp_q), 8'h00} : ram_rdata;
	end

	always_comb begin
		rp_d    = rp_q;
		wp_d    = wp_q;
		cnt_d   = cnt_q;
		vpp_d   = vpp_q;
		burst_d = burst_q;
		done_d  = done_q;
		fc_d    = fc_q;
		bus_d   = bus_q;
		dclk_d  = dclk_q;
		sil_d   = sil_q;
		mem_we  = 1'b0;
		driven  = 1'b0;
		dropped = 1'b0;
		unique case (cmd_s1.kind)
			CMD_PUSH: begin
				if (cnt_q == CNT_W'(FIFO_DEPTH)) begin
					dropped = 1'b1;
				end else begin
					mem_we = exec_fire;
					wp_d   = wp_inc;
					cnt_d  = cnt_q + 1'b1;
					for (int i = 0; i < SILENCE_N; i++) begin
						if (wp_q == PTR_W'(i)) begin
							sil_d[i] = 1'b0;
						end
					end
				end
			end
			CMD_FRAME: begin
				fc_d = fc_q + 2'd1;
				if (fc_d == 2'd0 && !done_q) begin
					burst_d = 1'b1;
				end
			end
			CMD_BUS: begin
				if (burst_q) begin
					if (cnt_q == '0) begin
						burst_d = 1'b0;
					end else if (vpp_q) begin
						bus_d  = head[7:0];
						dclk_d = 1'b0;
						vpp_d  = 1'b0;
						rp_d   = rp_inc;
						cnt_d  = cnt_q - 1'b1;
						driven = 1'b1;
					end else if (head[15:8] == end_song_q) begin
						// end of song wins when both codes match
						rp_d    = rp_inc;
						cnt_d   = cnt_q - 1'b1;
						burst_d = 1'b0;
						done_d  = 1'b1;
					end else if (head[15:8] == end_frame_q) begin
						rp_d    = rp_inc;
						cnt_d   = cnt_q - 1'b1;
						burst_d = 1'b0;
					end else begin
						bus_d  = head[15:8];
						dclk_d = 1'b1;
						vpp_d  = 1'b1;
						driven = 1'b1;
					end
				end
			end
			CMD_SONG: begin
				done_d = 1'b0;
			end
			CMD_FLUSH: begin
				rp_d    = '0;
				wp_d    = PTR_W'(SILENCE_WP);
				cnt_d   = CNT_W'(SILENCE_N);
				vpp_d   = 1'b0;
				sil_d   = '1;
				burst_d = 1'b1;
			end
			CMD_START: begin
				burst_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
		if (exec_fire) begin
			rsp_q.bus_value      <= bus_d;
			rsp_q.data_clock     <= dclk_d;
			rsp_q.frame_clock    <= fc_d[0];
			rsp_q.bus_phase_done <= driven;
			rsp_q.burst_active   <= burst_d;
			rsp_q.song_finished  <= done_d;
			rsp_q.fifo_level     <= 8'(cnt_d);
			rsp_q.push_dropped   <= dropped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ISSUE;
			rp_q        <= '0;
			wp_q        <= '0;
			cnt_q       <= '0;
			vpp_q       <= 1'b0;
			burst_q     <= 1'b0;
			done_q      <= 1'b0;
			fc_q        <= '0;
			bus_q       <= '0;
			dclk_q      <= 1'b0;
			sil_q       <= '0;
			end_song_q  <= END_SONG_RST;
			end_frame_q <= END_FRAME_RST;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_ISSUE: begin
					if (cmd_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_fire) begin
						state_q <= ST_ISSUE;
					end
				end
				default: state_q <= ST_ISSUE;
			endcase
			if (exec_fire) begin
				rp_q    <= rp_d;
				wp_q    <= wp_d;
				cnt_q   <= cnt_d;
				vpp_q   <= vpp_d;
				burst_q <= burst_d;
				done_q  <= done_d;
				fc_q    <= fc_d;
				bus_q   <= bus_d;
				dclk_q  <= dclk_d;
				sil_q   <= sil_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_END_SONG:  end_song_q  <= cfg_data;
					CFG_END_FRAME: end_frame_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	`RWBP_ASSERT(a_cnt_range, cnt_q <= CNT_W'(FIFO_DEPTH))
	`RWBP_ASSERT_IMP(a_value_phase_live, vpp_q, burst_q && cnt_q != '0)
	`RWBP_ASSERT_NEXT(a_flush_fill, exec_fire && cmd_s1.kind == CMD_FLUSH, cnt_q == CNT_W'(SILENCE_N) && rp_q == '0)
	`RWBP_ASSERT_IMP(a_drop_only_full, mem_we, cnt_q != CNT_W'(FIFO_DEPTH))

endmodule

FILE: rtl/register_write_burst_player.sv
// Register-write burst player: plays queued (address, value) pairs on an 8-bit bus.
// Depends on rwbp_pkg, rwbp_front, rwbp_back (which holds rwbp_ram).
//
// Request channel (req_valid/req_ready, payload req): push a pair, frame tick,
// bus tick, song start, FIFO flush or burst start. Every accepted request gives
// exactly one status transfer on the response channel (rsp_valid/rsp_ready, rsp).
// The front decodes requests into a two-entry command queue, so requests are taken
// while the back end is busy or a response waits.
// A request passes through the command queue, the back end's issue state, where
// the pair RAM's registered read fetches the FIFO head, and its execute state,
// which writes the response register; a new command is issued only after that one.
// Reset (arst_n low) empties the FIFO, stops the burst, clears song-done, frame
// count, bus byte and data clock, and loads the end-of-song and end-of-frame codes
// 0xFF and 0xF1. No clearing pass is needed; the block is ready right after reset.
// When the receiver holds rsp_ready low the result stays in place, the back end
// stops with one more request in hand, and req_ready drops once two further
// requests wait in the queue.
// Config writes (cfg_we, cfg_index, cfg_data) take effect at once and are meant
// for idle periods.
module register_write_burst_player (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  rwbp_pkg::in_item_t              req,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output rwbp_pkg::out_item_t             rsp,
	input  logic                            cfg_we,
	input  logic [rwbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rwbp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rwbp_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;

	rwbp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	rwbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
